[hw/rtl/sca_pkg.sv]
// ----------------------------------------------------------------------------
// sca_pkg: shared types and constants of the sector chain allocator
// Holds the table geometry, command and status codes, the controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sca_pkg;

	localparam int TABLE_AW    = 10;
	localparam int TABLE_SLOTS = 1 << TABLE_AW;
	localparam int ENTRY_AW    = 5;
	localparam int MAX_ENTRIES = 1 << ENTRY_AW;
	localparam int CNT_W       = TABLE_AW + 1;
	localparam int ENT_W       = ENTRY_AW + 1;
	localparam int BYTES_W     = 18;
	localparam int SIZE_SHIFT  = 7;
	localparam int NEED_W      = BYTES_W + 1 - SIZE_SHIFT;
	localparam logic [SIZE_SHIFT-1:0] SIZE_ROUND = 7'h7F;

	typedef struct packed {
		logic                free;
		logic                last;
		logic [TABLE_AW-1:0] next;
	} link_t;

	typedef enum logic [1:0] {
		CMD_STORE  = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_PEEK   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_DIR_FULL  = 2'd1,
		RS_NO_SPACE  = 2'd2,
		RS_BAD_INDEX = 2'd3
	} rstat_t;

	typedef enum logic [2:0] {
		ENG_CLEAR = 3'd0,
		ENG_COUNT = 3'd1,
		ENG_ALLOC = 3'd2,
		ENG_WALK  = 3'd3,
		ENG_FREE  = 3'd4,
		ENG_SHIFT = 3'd5
	} eng_op_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_CNT_GO,
		S_CNT_RUN,
		S_DIR_RD,
		S_WALK_GO,
		S_WALK_RUN,
		S_CHECK,
		S_BRANCH,
		S_FREE_GO,
		S_FREE_RUN,
		S_ALLOC_GO,
		S_ALLOC_RUN,
		S_DIR_WR,
		S_SHIFT_GO,
		S_SHIFT_RUN,
		S_PEEK_RD,
		S_PEEK_WT,
		S_FIN_GO,
		S_FIN_RUN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    eng_start;
		eng_op_t eng_op;
		logic    dir_rd;
		logic    chk;
		logic    dir_wr;
		logic    ent_dec;
		logic    peek_rd;
		logic    peek_cap;
		logic    out_load;
	} sca_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic is_new;
		logic fail;
		logic busy;
	} sca_stat_t;

endpackage

[hw/rtl/sca_dpath.sv]
// ----------------------------------------------------------------------------
// sca_dpath: allocator datapath
// Link table and directory memories, the slot engine that clears, counts,
// allocates, walks, frees and shifts, and the result registers.
// ----------------------------------------------------------------------------
module sca_dpath import sca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    active,
	input  logic [1:0]          cmd,
	input  logic                new_entry,
	input  logic [ENTRY_AW-1:0] entry_index,
	input  logic [BYTES_W-1:0]  byte_size,
	input  logic [TABLE_AW-1:0] sector,
	input  sca_ctl_t            ctl,
	output sca_stat_t           stat,
	output logic [1:0]          status,
	output logic [TABLE_AW-1:0] first_sector,
	output logic [CNT_W-1:0]    sector_count,
	output logic [TABLE_AW-1:0] next_sector,
	output logic                is_last,
	output logic                is_free,
	output logic [CNT_W-1:0]    free_count,
	output logic [ENT_W-1:0]    entry_count
);

	link_t               link_mem [TABLE_SLOTS];
	logic [TABLE_AW-1:0] dir_first_mem [MAX_ENTRIES];
	logic [CNT_W-1:0]    dir_cnt_mem [MAX_ENTRIES];

	link_t               lk_rd_q;
	logic [TABLE_AW-1:0] dir_first_rd_q;
	logic [CNT_W-1:0]    dir_cnt_rd_q;

	cmd_t                cmd_q;
	logic                new_q;
	logic [ENTRY_AW-1:0] eidx_q;
	logic [ENTRY_AW-1:0] idx_q;
	logic [NEED_W-1:0]   needed_q;
	logic [TABLE_AW-1:0] sector_q;
	logic [CNT_W-1:0]    n_q;
	rstat_t              rstat_q;
	logic [ENT_W-1:0]    entries_q;

	logic                busy_q;
	eng_op_t             op_q;
	logic [CNT_W-1:0]    addr_q;
	logic                pend_s1;
	logic [TABLE_AW-1:0] addr_s1;
	logic [CNT_W-1:0]    got_q;
	logic [TABLE_AW-1:0] prev_q;
	logic [TABLE_AW-1:0] first_q;
	logic [TABLE_AW-1:0] s_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    lim_q;
	logic [CNT_W-1:0]    c_q;
	logic [CNT_W-1:0]    acc_q;
	logic [TABLE_AW-1:0] next_q;
	logic                last_q;
	logic                isfree_q;

	rstat_t              pre_stat;
	logic [BYTES_W:0]    rounded;
	logic [NEED_W-1:0]   avail_sum;
	logic [CNT_W-1:0]    shift_nxt;
	logic                eng_issue;
	logic                eng_fin;
	logic                take;
	logic                lk_we;
	logic [TABLE_AW-1:0] lk_waddr;
	link_t               lk_wdata;
	logic [TABLE_AW-1:0] lk_raddr;
	logic                dir_re;
	logic [ENTRY_AW-1:0] dir_raddr;
	logic                dir_we;
	logic [ENTRY_AW-1:0] dir_waddr;
	logic [TABLE_AW-1:0] dir_wfirst;
	logic [CNT_W-1:0]    dir_wcnt;

	assign rounded   = {1'b0, byte_size} + (BYTES_W+1)'(SIZE_ROUND);
	assign avail_sum = NEED_W'(acc_q) + NEED_W'(c_q);
	assign shift_nxt = addr_q + CNT_W'(1);

	always_comb begin
		pre_stat = RS_OK;
		case (cmd_t'(cmd))
			CMD_STORE: begin
				if (new_entry) begin
					if (entries_q >= ENT_W'(MAX_ENTRIES))
						pre_stat = RS_DIR_FULL;
				end else if (ENT_W'(entry_index) >= entries_q) begin
					pre_stat = RS_BAD_INDEX;
				end
			end
			CMD_REMOVE: begin
				if (ENT_W'(entry_index) >= entries_q)
					pre_stat = RS_BAD_INDEX;
			end
			CMD_PEEK: begin
				if ((CNT_W+1)'(sector) >= (CNT_W+1)'(TABLE_SLOTS))
					pre_stat = RS_BAD_INDEX;
			end
			default: pre_stat = RS_OK;
		endcase
	end

	always_comb begin
		eng_issue = 1'b0;
		eng_fin   = 1'b0;
		take      = 1'b0;
		lk_we     = 1'b0;
		lk_waddr  = prev_q;
		lk_wdata  = '{free: 1'b1, last: 1'b0, next: '0};
		lk_raddr  = addr_q[TABLE_AW-1:0];
		dir_re    = ctl.dir_rd;
		dir_raddr = idx_q;
		dir_we    = ctl.dir_wr;
		dir_waddr = idx_q;
		dir_wfirst = first_q;
		dir_wcnt  = got_q;
		if (ctl.peek_rd)
			lk_raddr = sector_q;
		if (busy_q) begin
			case (op_q)
				ENG_CLEAR: begin
					lk_we    = 1'b1;
					lk_waddr = addr_q[TABLE_AW-1:0];
					eng_fin  = (addr_q == CNT_W'(TABLE_SLOTS - 1));
				end
				ENG_COUNT: begin
					eng_issue = (addr_q < n_q);
					eng_fin   = !eng_issue && !pend_s1;
				end
				ENG_ALLOC: begin
					eng_issue = (addr_q < n_q) && (NEED_W'(got_q) < needed_q);
					take      = pend_s1 && (NEED_W'(got_q) < needed_q) && lk_rd_q.free;
					eng_fin   = !eng_issue && !pend_s1;
					if (take && (got_q != '0)) begin
						lk_we    = 1'b1;
						lk_wdata = '{free: 1'b0, last: 1'b0, next: addr_s1};
					end
					if (eng_fin && (got_q != '0)) begin
						lk_we    = 1'b1;
						lk_wdata = '{free: 1'b0, last: 1'b1, next: '0};
					end
				end
				ENG_WALK, ENG_FREE: begin
					lk_raddr  = s_q;
					eng_issue = !pend_s1 && (k_q < lim_q);
					if (pend_s1) begin
						eng_fin = lk_rd_q.free || lk_rd_q.last;
						if ((op_q == ENG_FREE) && !lk_rd_q.free) begin
							lk_we    = 1'b1;
							lk_waddr = s_q;
						end
					end else begin
						eng_fin = !eng_issue;
					end
				end
				ENG_SHIFT: begin
					eng_issue = !pend_s1 && (shift_nxt < CNT_W'(entries_q));
					eng_fin   = !pend_s1 && !eng_issue;
					if (eng_issue) begin
						dir_re    = 1'b1;
						dir_raddr = shift_nxt[ENTRY_AW-1:0];
					end
					if (pend_s1) begin
						dir_we     = 1'b1;
						dir_waddr  = addr_q[ENTRY_AW-1:0];
						dir_wfirst = dir_first_rd_q;
						dir_wcnt   = dir_cnt_rd_q;
					end
				end
				default: eng_fin = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (lk_we)
			link_mem[lk_waddr] <= lk_wdata;
		lk_rd_q <= link_mem[lk_raddr];
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_first_mem[dir_waddr] <= dir_wfirst;
			dir_cnt_mem[dir_waddr]   <= dir_wcnt;
		end
		if (dir_re) begin
			dir_first_rd_q <= dir_first_mem[dir_raddr];
			dir_cnt_rd_q   <= dir_cnt_mem[dir_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			op_q      <= ENG_CLEAR;
			addr_q    <= '0;
			pend_s1   <= 1'b0;
			entries_q <= '0;
		end else begin
			if (ctl.dir_wr && new_q)
				entries_q <= entries_q + ENT_W'(1);
			if (ctl.ent_dec)
				entries_q <= entries_q - ENT_W'(1);
			if (ctl.eng_start) begin
				busy_q  <= 1'b1;
				op_q    <= ctl.eng_op;
				pend_s1 <= 1'b0;
				addr_q  <= (ctl.eng_op == ENG_SHIFT) ? CNT_W'(eidx_q) : '0;
			end else if (busy_q) begin
				pend_s1 <= eng_issue;
				if (eng_fin)
					busy_q <= 1'b0;
				case (op_q)
					ENG_CLEAR: addr_q <= addr_q + CNT_W'(1);
					ENG_COUNT, ENG_ALLOC: begin
						if (eng_issue)
							addr_q <= addr_q + CNT_W'(1);
					end
					ENG_SHIFT: begin
						if (pend_s1)
							addr_q <= shift_nxt;
					end
					default: addr_q <= addr_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr_q[TABLE_AW-1:0];
		if (ctl.load) begin
			cmd_q    <= cmd_t'(cmd);
			new_q    <= new_entry;
			eidx_q   <= entry_index;
			idx_q    <= (new_entry && (cmd_t'(cmd) == CMD_STORE)) ?
				entries_q[ENTRY_AW-1:0] : entry_index;
			needed_q <= NEED_W'(rounded >> SIZE_SHIFT);
			sector_q <= sector;
			n_q      <= (active > CNT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS) : active;
			rstat_q  <= pre_stat;
			got_q    <= '0;
			first_q  <= '0;
			c_q      <= '0;
			next_q   <= '0;
			last_q   <= 1'b0;
			isfree_q <= 1'b0;
		end
		if (ctl.chk && (avail_sum < needed_q))
			rstat_q <= RS_NO_SPACE;
		if (ctl.peek_cap) begin
			isfree_q <= lk_rd_q.free;
			last_q   <= !lk_rd_q.free && lk_rd_q.last;
			next_q   <= (lk_rd_q.free || lk_rd_q.last) ? '0 : lk_rd_q.next;
		end
		if (ctl.eng_start) begin
			if (ctl.eng_op == ENG_COUNT)
				acc_q <= '0;
			if (ctl.eng_op == ENG_WALK || ctl.eng_op == ENG_FREE) begin
				s_q   <= dir_first_rd_q;
				lim_q <= dir_cnt_rd_q;
				k_q   <= '0;
			end
		end else if (busy_q) begin
			case (op_q)
				ENG_COUNT: begin
					if (pend_s1 && lk_rd_q.free)
						acc_q <= acc_q + CNT_W'(1);
				end
				ENG_ALLOC: begin
					if (take) begin
						got_q  <= got_q + CNT_W'(1);
						prev_q <= addr_s1;
						if (got_q == '0)
							first_q <= addr_s1;
					end
				end
				ENG_WALK, ENG_FREE: begin
					if (pend_s1 && !lk_rd_q.free) begin
						if (CNT_W'(s_q) < n_q)
							c_q <= c_q + CNT_W'(1);
						s_q <= lk_rd_q.next;
						k_q <= k_q + CNT_W'(1);
					end
				end
				default: k_q <= k_q;
			endcase
		end
		if (ctl.out_load) begin
			status       <= rstat_q;
			first_sector <= first_q;
			sector_count <= got_q;
			next_sector  <= next_q;
			is_last      <= last_q;
			is_free      <= isfree_q;
			free_count   <= acc_q;
			entry_count  <= entries_q;
		end
	end

	assign stat = '{cmd: cmd_q, is_new: new_q, fail: (rstat_q != RS_OK), busy: busy_q};

endmodule

[hw/rtl/sca_ctrl.sv]
// ----------------------------------------------------------------------------
// sca_ctrl: allocator controller
// Sequences the datapath phases for each command and runs both handshakes.
// ----------------------------------------------------------------------------
module sca_ctrl import sca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	input  sca_stat_t stat,
	output sca_ctl_t  ctl
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (!stat.busy)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.fail) begin
					state_d = S_FIN_GO;
				end else begin
					case (stat.cmd)
						CMD_STORE:  state_d = S_CNT_GO;
						CMD_REMOVE: state_d = S_DIR_RD;
						CMD_PEEK:   state_d = S_PEEK_RD;
						default:    state_d = S_FIN_GO;
					endcase
				end
			end
			S_CNT_GO: state_d = S_CNT_RUN;
			S_CNT_RUN: begin
				if (!stat.busy)
					state_d = stat.is_new ? S_CHECK : S_DIR_RD;
			end
			S_DIR_RD:  state_d = S_WALK_GO;
			S_WALK_GO: state_d = S_WALK_RUN;
			S_WALK_RUN: begin
				if (!stat.busy)
					state_d = (stat.cmd == CMD_REMOVE) ? S_SHIFT_GO : S_CHECK;
			end
			S_CHECK: state_d = S_BRANCH;
			S_BRANCH: begin
				if (stat.fail)
					state_d = S_FIN_GO;
				else
					state_d = stat.is_new ? S_ALLOC_GO : S_FREE_GO;
			end
			S_FREE_GO: state_d = S_FREE_RUN;
			S_FREE_RUN: begin
				if (!stat.busy)
					state_d = S_ALLOC_GO;
			end
			S_ALLOC_GO: state_d = S_ALLOC_RUN;
			S_ALLOC_RUN: begin
				if (!stat.busy)
					state_d = S_DIR_WR;
			end
			S_DIR_WR:   state_d = S_FIN_GO;
			S_SHIFT_GO: state_d = S_SHIFT_RUN;
			S_SHIFT_RUN: begin
				if (!stat.busy)
					state_d = S_FIN_GO;
			end
			S_PEEK_RD: state_d = S_PEEK_WT;
			S_PEEK_WT: state_d = S_FIN_GO;
			S_FIN_GO:  state_d = S_FIN_RUN;
			S_FIN_RUN: begin
				if (!stat.busy)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (slot_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '{load: 1'b0, eng_start: 1'b0, eng_op: ENG_COUNT, dir_rd: 1'b0, chk: 1'b0,
			dir_wr: 1'b0, ent_dec: 1'b0, peek_rd: 1'b0, peek_cap: 1'b0, out_load: 1'b0};
		case (state_q)
			S_IDLE:   ctl.load = req_valid;
			S_CNT_GO: ctl.eng_start = 1'b1;
			S_DIR_RD: ctl.dir_rd = 1'b1;
			S_WALK_GO: begin
				ctl.eng_start = 1'b1;
				ctl.eng_op    = (stat.cmd == CMD_REMOVE) ? ENG_FREE : ENG_WALK;
			end
			S_CHECK: ctl.chk = 1'b1;
			S_FREE_GO: begin
				ctl.eng_start = 1'b1;
				ctl.eng_op    = ENG_FREE;
			end
			S_ALLOC_GO: begin
				ctl.eng_start = 1'b1;
				ctl.eng_op    = ENG_ALLOC;
			end
			S_DIR_WR: ctl.dir_wr = 1'b1;
			S_SHIFT_GO: begin
				ctl.eng_start = 1'b1;
				ctl.eng_op    = ENG_SHIFT;
			end
			S_SHIFT_RUN: ctl.ent_dec = !stat.busy;
			S_PEEK_RD:   ctl.peek_rd = 1'b1;
			S_PEEK_WT:   ctl.peek_cap = 1'b1;
			S_FIN_GO:    ctl.eng_start = 1'b1;
			S_OUT:       ctl.out_load = slot_free;
			default:     ctl.load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

[hw/rtl/sector_chain_allocator.sv]
// ----------------------------------------------------------------------------
// sector_chain_allocator: chain allocator over a sector link table
// Keeps a link table of sector chains and a small directory of entries, and
// serves store, remove and successor queries one request at a time.
// ----------------------------------------------------------------------------
// A request beat is taken when req_valid is high and req_stall is low; each
// request yields exactly one response beat on rsp_valid / rsp_stall.
// After reset the block sweeps all TABLE_SLOTS (1024) slots of the link table
// to mark them free; req_stall stays high during the sweep.
// One request is worked on at a time. Every request ends with a scan of the
// n active slots for the free count (n = min(active_sectors, 1024)). A store
// adds another scan of the n active slots, an allocation scan and, when it
// replaces an entry, two chain walks. A remove adds one chain walk and a
// shift that moves the later directory entries down. A successor query adds
// a read of the link of its sector.
// The response is held in an output register: the next request can start
// while it waits, and a stalled response keeps its value until taken.
// active_sectors is written over the APB port at address 0 and should only
// change while no request is in flight.
// ----------------------------------------------------------------------------
module sector_chain_allocator import sca_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          cmd,
	input  logic                new_entry,
	input  logic [ENTRY_AW-1:0] entry_index,
	input  logic [BYTES_W-1:0]  byte_size,
	input  logic [TABLE_AW-1:0] sector,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          status,
	output logic [TABLE_AW-1:0] first_sector,
	output logic [CNT_W-1:0]    sector_count,
	output logic [TABLE_AW-1:0] next_sector,
	output logic                is_last,
	output logic                is_free,
	output logic [CNT_W-1:0]    free_count,
	output logic [ENT_W-1:0]    entry_count
);

	logic [CNT_W-1:0] active_q;
	sca_ctl_t         ctl;
	sca_stat_t        stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, active_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= CNT_W'(917);
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			active_q <= pwdata[CNT_W-1:0];
		end
	end

	sca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	sca_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.active       (active_q),
		.cmd          (cmd),
		.new_entry    (new_entry),
		.entry_index  (entry_index),
		.byte_size    (byte_size),
		.sector       (sector),
		.ctl          (ctl),
		.stat         (stat),
		.status       (status),
		.first_sector (first_sector),
		.sector_count (sector_count),
		.next_sector  (next_sector),
		.is_last      (is_last),
		.is_free      (is_free),
		.free_count   (free_count),
		.entry_count  (entry_count)
	);

endmodule
